// ===== rtl/lvwd_pkg.sv =====
package lvwd_pkg;

    // Default lattice geometry
    localparam int LATTICE_SIDE_DEF = 64;
    localparam int MAX_RADIUS_DEF   = 24;

    // Field widths
    localparam int COORD_W  = 6;
    localparam int ANGLE_W  = 16;
    localparam int RADIUS_W = 5;
    localparam int LIMIT_W  = 15;
    localparam int WIND_W   = 8;

    // Step limit after reset, about 0.45 pi in phase units
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 15'd14746;

    // Winding saturation bounds
    localparam int WIND_SAT = 64;

    // Input actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic REG_STEP_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        KIND_NONE              = 3'd0,
        KIND_VORTEX            = 3'd1,
        KIND_ANTIVORTEX        = 3'd2,
        KIND_DOUBLE_VORTEX     = 3'd3,
        KIND_DOUBLE_ANTIVORTEX = 3'd4
    } t_kind;

    typedef struct packed {
        logic                action;
        logic [COORD_W-1:0]  site_x;
        logic [COORD_W-1:0]  site_y;
        logic [ANGLE_W-1:0]  angle;
        logic [RADIUS_W-1:0] radius;
    } t_item;

    typedef struct packed {
        t_kind                    kind;
        logic signed [WIND_W-1:0] winding;
        logic                     aborted;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic norm_step;
        logic mem_write;
        logic rd_en;
        logic advance;
        logic load_result;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic norm_done;
        logic is_write;
        logic zero_radius;
        logic walk_last;
    } t_stat;

endpackage

// ===== rtl/lvwd_ctrl.sv =====
module lvwd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lvwd_pkg::t_stat  i_stat,
    output lvwd_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import lvwd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_NORM;
                end
            end
            ST_NORM: begin
                // bring both coordinates into the lattice
                if (!i_stat.norm_done) begin
                    o_cmd.norm_step = 1'b1;
                end else if (i_stat.is_write) begin
                    n_state = ST_WRITE;
                end else if (i_stat.zero_radius) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WRITE: begin
                o_cmd.mem_write = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_WALK: begin
                // one site read per cycle around the loop
                o_cmd.rd_en = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_DRAIN1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_FINISH;
            ST_FINISH: begin
                o_cmd.load_result = 1'b1;
                n_state           = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/lvwd_datapath.sv =====
module lvwd_datapath #(
    parameter int LATTICE_SIDE = lvwd_pkg::LATTICE_SIDE_DEF,
    parameter int MAX_RADIUS   = lvwd_pkg::MAX_RADIUS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lvwd_pkg::t_item                      i_item,
    input  logic [lvwd_pkg::LIMIT_W-1:0]         i_step_limit,
    input  lvwd_pkg::t_cmd                       i_cmd,
    output lvwd_pkg::t_stat                      o_stat,
    output lvwd_pkg::t_result                    o_result,
    output logic                                 o_valid
);
    import lvwd_pkg::*;

    localparam int CW    = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
    localparam int DEPTH = LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_RADIUS + 64 + LATTICE_SIDE) + 1;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int JW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int SW    = $clog2(8 * MAX_RADIUS) + ANGLE_W + 1;
    localparam int WW    = SW - ANGLE_W;

    localparam logic signed [NW-1:0]       SIDE_N  = NW'(LATTICE_SIDE);
    localparam logic signed [NW-1:0]       LAST_N  = NW'(LATTICE_SIDE - 1);
    localparam logic signed [ANGLE_W+1:0]  HALF_T  = (ANGLE_W+2)'(32768);
    localparam logic signed [ANGLE_W+1:0]  FULL_T  = (ANGLE_W+2)'(65536);

    // Lattice memory
    logic [ANGLE_W-1:0] r_mem [DEPTH];
    logic [ANGLE_W-1:0] r_rdata;

    // Item registers
    logic                     r_action;
    logic [ANGLE_W-1:0]       r_angle;
    logic [RW-1:0]            r_radius;
    logic [JW-1:0]            r_twor;
    logic signed [NW-1:0]     r_vx;
    logic signed [NW-1:0]     r_vy;

    // Walk counters
    logic [JW-1:0]            r_j;
    logic [1:0]               r_side;
    logic                     r_at_end;

    // Difference pipeline
    logic                     r_rv;
    logic                     r_first;
    logic [ANGLE_W-1:0]       r_prev;
    logic                     r_dv;
    logic signed [ANGLE_W:0]  r_d;
    logic signed [SW-1:0]     r_sum;
    logic                     r_abort;

    t_result                  r_result;
    logic                     r_valid;

    logic [RW-1:0]            radius_c;
    logic [AW-1:0]            addr;
    logic signed [ANGLE_W+1:0] raw_d;
    logic signed [ANGLE_W+1:0] wrap_d;
    logic [ANGLE_W:0]         mag;
    logic [JW-1:0]            n_j;
    logic [1:0]               n_side;
    logic signed [NW-1:0]     n_vx;
    logic signed [NW-1:0]     n_vy;
    logic signed [NW-1:0]     norm_vx;
    logic signed [NW-1:0]     norm_vy;
    logic signed [WW-1:0]     wind_w;
    int                       wind_i;
    t_result                  res_c;

    // Radius clamp
    always_comb begin
        if (32'(i_item.radius) > MAX_RADIUS) begin
            radius_c = RW'(MAX_RADIUS);
        end else begin
            radius_c = RW'(i_item.radius);
        end
    end

    // Lattice address from the current coordinates
    assign addr = AW'(r_vy[CW-1:0]) * AW'(LATTICE_SIDE) + AW'(r_vx[CW-1:0]);

    // One reduction step per cycle into [0, side-1]
    always_comb begin
        if (r_vx < 0) begin
            norm_vx = r_vx + SIDE_N;
        end else if (r_vx >= SIDE_N) begin
            norm_vx = r_vx - SIDE_N;
        end else begin
            norm_vx = r_vx;
        end
        if (r_vy < 0) begin
            norm_vy = r_vy + SIDE_N;
        end else if (r_vy >= SIDE_N) begin
            norm_vy = r_vy - SIDE_N;
        end else begin
            norm_vy = r_vy;
        end
    end

    // Loop position: counter within the side, then a step in the new side's direction
    always_comb begin
        n_j    = r_j + JW'(1);
        n_side = r_side;
        if (n_j == r_twor) begin
            n_j    = '0;
            n_side = r_side + 2'd1;
        end
        n_vx = r_vx;
        n_vy = r_vy;
        unique case (n_side)
            2'd0: n_vx = (r_vx == LAST_N) ? '0 : r_vx + NW'(1);
            2'd1: n_vy = (r_vy == LAST_N) ? '0 : r_vy + NW'(1);
            2'd2: n_vx = (r_vx == '0) ? LAST_N : r_vx - NW'(1);
            2'd3: n_vy = (r_vy == '0) ? LAST_N : r_vy - NW'(1);
            default: n_vx = r_vx;
        endcase
    end

    // Coordinates and walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_angle  <= i_item.angle;
            r_radius <= radius_c;
            r_twor   <= JW'(radius_c) << 1;
            if (i_item.action == ACT_WRITE) begin
                r_vx <= NW'(i_item.site_x);
                r_vy <= NW'(i_item.site_y);
            end else begin
                r_vx <= NW'(i_item.site_x) - NW'(radius_c) + NW'(1);
                r_vy <= NW'(i_item.site_y) - NW'(radius_c);
            end
            r_j      <= '0;
            r_side   <= '0;
            r_at_end <= 1'b0;
        end else if (i_cmd.norm_step) begin
            r_vx <= norm_vx;
            r_vy <= norm_vy;
        end else if (i_cmd.advance) begin
            r_vx     <= n_vx;
            r_vy     <= n_vy;
            r_j      <= n_j;
            r_side   <= n_side;
            r_at_end <= (n_side == 2'd0) && (n_j == '0);
        end
    end

    // Memory port: one write or one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[addr] <= r_angle;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    // Wrapped phase difference into [-half, half]
    always_comb begin
        raw_d = $signed({2'b00, r_rdata}) - $signed({2'b00, r_prev});
        if (raw_d > HALF_T) begin
            wrap_d = raw_d - FULL_T;
        end else if (raw_d < -HALF_T) begin
            wrap_d = raw_d + FULL_T;
        end else begin
            wrap_d = raw_d;
        end
    end

    assign mag = (r_d < 0) ? (ANGLE_W+1)'(-r_d) : (ANGLE_W+1)'(r_d);

    // Difference and accumulation stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
            r_dv <= 1'b0;
        end else begin
            r_rv <= i_cmd.rd_en;
            r_dv <= r_rv && !r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= 1'b1;
            r_sum   <= '0;
            r_abort <= 1'b0;
        end else begin
            if (r_rv) begin
                r_first <= 1'b0;
                r_prev  <= r_rdata;
                r_d     <= (ANGLE_W+1)'(wrap_d);
            end
            if (r_dv) begin
                if (mag > (ANGLE_W+1)'(i_step_limit)) begin
                    r_abort <= 1'b1;
                end else if (!r_abort) begin
                    r_sum <= r_sum + SW'(r_d);
                end
            end
        end
    end

    // Winding number and its class; the sum is a whole number of turns
    assign wind_w = r_sum[SW-1:ANGLE_W];
    assign wind_i = int'(wind_w);

    always_comb begin
        res_c.aborted = r_abort;
        if (r_abort) begin
            res_c.kind    = KIND_NONE;
            res_c.winding = '0;
        end else begin
            if (wind_i >= 2) begin
                res_c.kind = KIND_DOUBLE_VORTEX;
            end else if (wind_i == 1) begin
                res_c.kind = KIND_VORTEX;
            end else if (wind_i <= -2) begin
                res_c.kind = KIND_DOUBLE_ANTIVORTEX;
            end else if (wind_i == -1) begin
                res_c.kind = KIND_ANTIVORTEX;
            end else begin
                res_c.kind = KIND_NONE;
            end
            if (wind_i > WIND_SAT) begin
                res_c.winding = WIND_W'(WIND_SAT);
            end else if (wind_i < -WIND_SAT) begin
                res_c.winding = WIND_W'(-WIND_SAT);
            end else begin
                res_c.winding = WIND_W'(wind_i);
            end
        end
    end

    // Result register and one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_result <= res_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.load_result;
        end
    end

    assign o_stat.norm_done   = (r_vx >= 0) && (r_vx < SIDE_N) && (r_vy >= 0) && (r_vy < SIDE_N);
    assign o_stat.is_write    = (r_action == ACT_WRITE);
    assign o_stat.zero_radius = (r_radius == '0);
    assign o_stat.walk_last   = r_at_end;

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule

// ===== rtl/lattice_vortex_winding_detector_unit.sv =====
// Winding number detector over a periodic square lattice of spin phases.
// Input: an item is taken at a clock edge with start high and busy low.
//   action 0 stores angle at (site_x, site_y); action 1 queries the
//   winding around that site on the square loop of half side radius
//   (radius clamped to MAX_RADIUS, coordinates wrap around the lattice).
// Output: one result per query, shown for a single cycle with o_valid;
//   the receiver takes it in that cycle and cannot stall the block.
//   Writes give no result.
// Timing: a write holds busy through coordinate reduction and the write state.
//   A query reads the 8r+1 loop sites through the single lattice memory
//   port, one per cycle; after the walk come the drain states, the finish
//   state and the result register before o_valid (coordinates need at most
//   one reduction step when the lattice side is 64).
//   A new item is accepted in the cycle the result is shown.
// Config: APB register step_limit at byte address 0, written with the
//   block idle. pready is always high.
// Reset: i_rst_n (synchronous, active low) returns the controller to idle,
//   drops o_valid and sets step_limit to 14746. Lattice contents are
//   undefined until written; reading an unwritten site gives any value.
module lattice_vortex_winding_detector_unit #(
    parameter int LATTICE_SIDE = lvwd_pkg::LATTICE_SIDE_DEF,
    parameter int MAX_RADIUS   = lvwd_pkg::MAX_RADIUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lvwd_pkg::t_item   i_item,
    output logic              o_valid,
    output lvwd_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import lvwd_pkg::*;

    logic [LIMIT_W-1:0] r_step_limit;
    logic               cfg_wr;
    t_cmd               cmd;
    t_stat              stat;

    // Configuration register transfer
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_LIMIT_RESET;
        end else if (cfg_wr && (paddr[2] == REG_STEP_LIMIT)) begin
            r_step_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_STEP_LIMIT) ? {{(32-LIMIT_W){1'b0}}, r_step_limit} : '0;
    assign pready = 1'b1;

    lvwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lvwd_datapath #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .MAX_RADIUS   (MAX_RADIUS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_step_limit (r_step_limit),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_result     (o_result),
        .o_valid      (o_valid)
    );

`ifndef SYNTHESIS
    // An accepted item raises busy in the cycle after it is taken
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after item transfer");

    // A result comes out only once the walk has finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while block busy");

    // Each result transfer lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== dv/tb_lattice_vortex_winding_detector_unit.sv =====
`timescale 1ns / 1ps

module tb_lattice_vortex_winding_detector_unit;
    import lvwd_pkg::*;

    localparam int SIDE_MASK   = LATTICE_SIDE_DEF - 1;
    localparam int LOOP_MAX_R  = MAX_RADIUS_DEF;
    localparam int HALF_PHASE  = 32768;
    localparam int FULL_PHASE  = 65536;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam logic [2:0] STEP_LIMIT_ADDR = 3'({2'b00, REG_STEP_LIMIT} << 2);

    // DUT ports
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_item       i_item  = '0;
    logic        o_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard state
    t_item              pending_items[$];
    t_result            expected_results[$];
    logic [ANGLE_W-1:0] lat_phase[0:LATTICE_SIDE_DEF*LATTICE_SIDE_DEF-1];
    bit                 lat_written[0:LATTICE_SIDE_DEF*LATTICE_SIDE_DEF-1];
    logic [LIMIT_W-1:0] limit_model = STEP_LIMIT_RESET;
    int                 stim_count    = 0;
    int                 err_count     = 0;
    int                 cfg_err_count = 0;
    int                 cycle_count   = 0;
    int                 idle_left     = 0;
    int                 issued        = 0;
    int                 accepted      = 0;
    bit                 quiet_tail    = 1'b0;
    t_result            want_res;

    lattice_vortex_winding_detector_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // Lattice index of position k on the square loop of half side r around (cx, cy)
    function automatic logic [2*COORD_W-1:0] loop_site(logic [COORD_W-1:0] cx,
                                                        logic [COORD_W-1:0] cy,
                                                        int r, int k);
        int side;
        int i;
        int px;
        int py;
        side = k / (2 * r);
        i    = -r + 1 + (k % (2 * r));
        case (side)
            0: begin
                px = cx + i;
                py = cy - r;
            end
            1: begin
                px = cx + r;
                py = cy + i;
            end
            2: begin
                px = cx - i;
                py = cy + r;
            end
            default: begin
                px = cx - r;
                py = cy - i;
            end
        endcase
        return {COORD_W'(py & SIDE_MASK), COORD_W'(px & SIDE_MASK)};
    endfunction

    // Winding along the loop, with abort on an oversized step
    function automatic t_result predict_winding(t_item it);
        t_result res;
        int      r;
        int      n;
        int      k;
        int      sum;
        int      prev;
        int      cur;
        int      d;
        int      mag;
        int      w;
        bit      abort_walk;
        r          = it.radius;
        sum        = 0;
        abort_walk = 1'b0;
        if (r > LOOP_MAX_R) r = LOOP_MAX_R;
        if (r > 0) begin
            n    = 8 * r;
            prev = lat_phase[loop_site(it.site_x, it.site_y, r, 0)];
            for (k = 1; k <= n && !abort_walk; k++) begin
                cur = lat_phase[loop_site(it.site_x, it.site_y, r, k % n)];
                d   = cur - prev;
                if (d > HALF_PHASE) d -= FULL_PHASE;
                else if (d < -HALF_PHASE) d += FULL_PHASE;
                mag = (d < 0) ? -d : d;
                if (mag > int'(limit_model)) begin
                    abort_walk = 1'b1;
                end else begin
                    sum += d;
                    prev = cur;
                end
            end
        end
        if (abort_walk) begin
            res.kind    = KIND_NONE;
            res.winding = '0;
            res.aborted = 1'b1;
            return res;
        end
        w = sum / FULL_PHASE;
        if (w >= 2) res.kind = KIND_DOUBLE_VORTEX;
        else if (w == 1) res.kind = KIND_VORTEX;
        else if (w <= -2) res.kind = KIND_DOUBLE_ANTIVORTEX;
        else if (w == -1) res.kind = KIND_ANTIVORTEX;
        else res.kind = KIND_NONE;
        if (w > WIND_SAT) w = WIND_SAT;
        if (w < -WIND_SAT) w = -WIND_SAT;
        res.winding = WIND_W'(w);
        res.aborted = 1'b0;
        return res;
    endfunction

    task automatic queue_item(t_item it);
        pending_items = {pending_items, it};
        stim_count++;
    endtask

    task automatic queue_write(logic [2*COORD_W-1:0] site, logic [ANGLE_W-1:0] angle);
        t_item it;
        it.action = ACT_WRITE;
        it.site_x = site[COORD_W-1:0];
        it.site_y = site[2*COORD_W-1:COORD_W];
        it.angle  = angle;
        it.radius = RADIUS_W'($urandom);
        lat_written[site] = 1'b1;
        queue_item(it);
    endtask

    // Unwritten loop sites first get a smooth background, then the query goes out
    task automatic queue_query(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, int radius);
        t_item                it;
        int                   r;
        int                   k;
        logic [2*COORD_W-1:0] site;
        r = (radius > LOOP_MAX_R) ? LOOP_MAX_R : radius;
        for (k = 0; k < 8 * r; k++) begin
            site = loop_site(cx, cy, r, k);
            if (!lat_written[site])
                queue_write(site, ANGLE_W'(int'(site[COORD_W-1:0]) * 1024 +
                                           int'(site[2*COORD_W-1:COORD_W]) * 3072));
        end
        it.action = ACT_QUERY;
        it.site_x = cx;
        it.site_y = cy;
        it.angle  = ANGLE_W'($urandom);
        it.radius = RADIUS_W'(radius);
        queue_item(it);
    endtask

    // Write a loop whose phase turns w times, plus optional per-site jitter
    task automatic queue_paint(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, int r,
                               int w, int noise, logic [ANGLE_W-1:0] base);
        int n;
        int k;
        int ph;
        n = 8 * r;
        for (k = 0; k < n; k++) begin
            ph = int'(base) + (k * w * FULL_PHASE) / n;
            if (noise > 0) ph += int'($urandom_range(0, 2 * noise)) - noise;
            queue_write(loop_site(cx, cy, r, k), ANGLE_W'(ph));
        end
    endtask

    // Mostly painted loops followed by a query, some loose writes and queries
    task automatic queue_random_phase(int n_items);
        int               stop_at;
        int               pick;
        int               raw_r;
        int               r;
        int               w;
        int               wmax;
        int               noise;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        stop_at = stim_count + n_items;
        while (stim_count < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                queue_write(12'($urandom), ANGLE_W'($urandom));
            end else if (pick < 6) begin
                // loose queries stay small most of the time
                raw_r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 3);
                queue_query(COORD_W'($urandom), COORD_W'($urandom), raw_r);
            end else begin
                cx   = COORD_W'($urandom);
                cy   = COORD_W'($urandom);
                pick = $urandom_range(0, 19);
                if (pick < 16) raw_r = $urandom_range(1, 3);
                else if (pick < 19) raw_r = $urandom_range(4, 8);
                else raw_r = $urandom_range(9, 31);
                r     = (raw_r > LOOP_MAX_R) ? LOOP_MAX_R : raw_r;
                noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000)
                                                    : $urandom_range(0, 300);
                wmax  = (int'(limit_model) * 8 * r) / FULL_PHASE;
                if (wmax == 0 || $urandom_range(0, 7) == 0) w = int'($urandom_range(0, 12)) - 6;
                else w = int'($urandom_range(0, 2 * wmax)) - wmax;
                queue_paint(cx, cy, r, w, noise, ANGLE_W'($urandom));
                case ($urandom_range(0, 9))
                    0: queue_query(cx, cy, $urandom_range(0, 31));
                    1: queue_query(cx + COORD_W'($urandom_range(0, 2)) - 1'b1,
                                   cy + COORD_W'($urandom_range(0, 2)) - 1'b1, raw_r);
                    2: begin
                        queue_write(loop_site(cx, cy, r, $urandom_range(0, 8 * r - 1)),
                                    ANGLE_W'($urandom));
                        queue_query(cx, cy, raw_r);
                    end
                    default: queue_query(cx, cy, raw_r);
                endcase
            end
        end
    endtask

    // Drain all work, then let trailing writes settle
    task automatic wait_idle(int settle);
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // One APB transfer to the step limit register
    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= STEP_LIMIT_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_step_limit();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[LIMIT_W-1:0] !== limit_model) begin
            $display("%0t: step_limit readback expected %0d actual %0d",
                     $time, limit_model, rd[LIMIT_W-1:0]);
            cfg_err_count++;
        end
    endtask

    task automatic set_step_limit(logic [LIMIT_W-1:0] val);
        logic [31:0] rd;
        wait_idle(16);
        apb_access(1'b1, 32'(val), rd);
        limit_model = val;
        check_step_limit();
    endtask

    // Driver: present items at the falling edge, with random idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && accepted != issued) begin
            // hold until the block takes the item
        end else begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_items.size() == 0) begin
                start <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(0, 3);
                start <= 1'b0;
            end else begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
                issued++;
            end
        end
    end

    // Accepted transfers update the lattice copy or queue a prediction
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            accepted++;
            if (i_item.action == ACT_WRITE)
                lat_phase[{i_item.site_y, i_item.site_x}] = i_item.angle;
            else
                expected_results = {expected_results, predict_winding(i_item)};
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none actual kind %0d winding %0d aborted %0d",
                         $time, o_result.kind, $signed(o_result.winding), o_result.aborted);
                err_count++;
            end else begin
                want_res = expected_results.pop_front();
                if (o_result.kind !== want_res.kind) begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want_res.kind, o_result.kind);
                    err_count++;
                end
                if (o_result.winding !== want_res.winding) begin
                    $display("%0t: winding expected %0d actual %0d",
                             $time, $signed(want_res.winding), $signed(o_result.winding));
                    err_count++;
                end
                if (o_result.aborted !== want_res.aborted) begin
                    $display("%0t: aborted expected %0d actual %0d",
                             $time, want_res.aborted, o_result.aborted);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lattice_vortex_winding_detector_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int                 ph;
        logic [LIMIT_W-1:0] lim;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_step_limit();

        // Directed: empty loop, smooth loop across the wrap, single vortices,
        // clamped radius, and an abort from one bad site
        queue_query(6'd5, 6'd5, 0);
        queue_query(6'd0, 6'd0, 1);
        queue_paint(6'd20, 6'd20, 1, 1, 0, 16'h0000);
        queue_query(6'd20, 6'd20, 1);
        queue_paint(6'd40, 6'd12, 1, -1, 0, 16'h1234);
        queue_query(6'd40, 6'd12, 1);
        queue_query(6'd63, 6'd63, 31);
        queue_write({6'd19, 6'd20}, 16'h8000);
        queue_query(6'd20, 6'd20, 1);

        // Step exactly at the limit passes, one above aborts
        set_step_limit(15'd8192);
        queue_query(6'd40, 6'd12, 1);
        set_step_limit(15'd8191);
        queue_query(6'd40, 6'd12, 1);

        // Widest limit: double vortices and saturated winding
        set_step_limit(LIMIT_MAX);
        queue_paint(6'd30, 6'd40, 1, 2, 0, 16'hFFFF);
        queue_query(6'd30, 6'd40, 1);
        queue_paint(6'd50, 6'd50, 1, -2, 0, 16'h0000);
        queue_query(6'd50, 6'd50, 1);
        queue_paint(6'd32, 6'd32, LOOP_MAX_R, 66, 0, 16'h0100);
        queue_query(6'd32, 6'd32, LOOP_MAX_R);
        queue_query(6'd32, 6'd32, 31);
        queue_paint(6'd10, 6'd45, LOOP_MAX_R, -66, 0, 16'hABCD);
        queue_query(6'd10, 6'd45, LOOP_MAX_R);

        // Zero limit: flat loop passes, any slope aborts
        set_step_limit('0);
        queue_paint(6'd5, 6'd50, 2, 0, 0, 16'h7777);
        queue_query(6'd5, 6'd50, 2);
        queue_query(6'd0, 6'd0, 1);

        // Random phases over several limits; the last runs without idling
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: lim = LIMIT_MAX;
                1: lim = LIMIT_W'($urandom);
                2: lim = LIMIT_W'($urandom_range(0, 4000));
                3: lim = STEP_LIMIT_RESET;
                default: lim = LIMIT_W'($urandom_range(8192, 32767));
            endcase
            set_step_limit(lim);
            if (ph == 4) quiet_tail = 1'b1;
            queue_random_phase(100);
        end

        wait_idle(250);
        if (err_count == 0 && cfg_err_count == 0)
            $display("lattice_vortex_winding_detector_unit regression: pass");
        else
            $display("lattice_vortex_winding_detector_unit regression: fail");
        $finish;
    end

endmodule
